// ----- sv/pq_pkg.sv -----
// ----------------------------------------------------------------------------
// pq_pkg
// Shared types and constants for the heap priority queue.
// ----------------------------------------------------------------------------
package pq_pkg;
    localparam int CAPACITY    = 64;
    localparam int VALUE_WIDTH = 32;
    localparam int AW          = $clog2(CAPACITY);
    localparam int CW          = $clog2(CAPACITY + 1);

    localparam logic [1:0] ACT_PUSH = 2'd0;
    localparam logic [1:0] ACT_POP  = 2'd1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    localparam logic [0:0] REG_ORDER = 1'd0;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD0,
        S_DN_NEXT,
        S_DN_RDL,
        S_DN_RDR,
        S_DN_CMP,
        S_TOP_RD,
        S_TOP_WAIT,
        S_DONE
    } t_state;

    function automatic logic outranks(input logic min_first,
                                      input logic [VALUE_WIDTH-1:0] a,
                                      input logic [VALUE_WIDTH-1:0] b);
        outranks = min_first ? (a < b) : (a > b);
    endfunction
endpackage

// ----- sv/pq_ram.sv -----
// ----------------------------------------------------------------------------
// pq_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module pq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ----- sv/priority_queue_core.sv -----
// ----------------------------------------------------------------------------
// priority_queue_core
// Bounded binary-heap priority queue, max-first or min-first.
// ----------------------------------------------------------------------------
// channel   direction  transfer when
// command   in         i_start && !o_busy (i_action, i_value)
// result    out        o_done, one cycle (o_top_value, o_not_empty, o_count, o_status)
// config    in         psel && penable && pwrite (pready always high)
//
// A report or refused command only reads the root. Push writes at the tail,
// then reads and compares each parent, plus a write when the value reaches
// the root. Pop reads the last entry, then reads each level's children and
// compares, going down after each swap. One RAM port serves all reads and
// writes. Reset clears state, count and order, not RAM. Results cannot be stalled.
// ----------------------------------------------------------------------------
module priority_queue_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [1:0]  i_action,
    input  logic [31:0] i_value,
    output logic        o_busy,
    output logic        o_done,
    output logic [31:0] o_top_value,
    output logic        o_not_empty,
    output logic [6:0]  o_count,
    output logic [1:0]  o_status,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int VW = pq_pkg::VALUE_WIDTH;
    localparam int AW = pq_pkg::AW;
    localparam int CW = pq_pkg::CW;

    pq_pkg::t_state r_state, n_state;
    logic [CW-1:0]  r_cnt, n_cnt;
    logic [AW-1:0]  r_pos, n_pos;
    logic [AW-1:0]  r_best, n_best;
    logic [VW-1:0]  r_cur, n_cur;
    logic [VW-1:0]  r_left, n_left;
    logic [1:0]     r_status, n_status;
    logic           r_min;
    logic [VW-1:0]  r_top, n_top;
    logic           r_done;

    logic           we;
    logic [AW-1:0]  addr;
    logic [VW-1:0]  wdata, rdata;

    pq_ram #(.WIDTH(VW), .DEPTH(pq_pkg::CAPACITY)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_addr(addr), .i_wdata(wdata), .o_rdata(rdata)
    );

    assign pready = 1'b1;
    assign prdata = {31'd0, r_min};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= 1'b0;
        end else if (psel && penable && pwrite && paddr[1:1] == pq_pkg::REG_ORDER) begin
            r_min <= pwdata[0];
        end
    end

    logic [AW:0] lidx, ridx;
    assign lidx = {r_pos, 1'b1};
    assign ridx = {r_pos, 1'b0} + (AW+1)'(2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pq_pkg::S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_pos    <= n_pos;
        r_best   <= n_best;
        r_cur    <= n_cur;
        r_left   <= n_left;
        r_status <= n_status;
        r_top    <= n_top;
    end

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_pos    = r_pos;
        n_best   = r_best;
        n_cur    = r_cur;
        n_left   = r_left;
        n_status = r_status;
        n_top    = r_top;
        we       = 1'b0;
        addr     = '0;
        wdata    = r_cur;
        case (r_state)
            pq_pkg::S_IDLE: begin
                if (i_start && !r_done) begin
                    n_status = pq_pkg::ST_OK;
                    n_cur    = i_value[VW-1:0];
                    n_state  = pq_pkg::S_TOP_RD;
                    if (i_action == pq_pkg::ACT_PUSH) begin
                        if (r_cnt >= CW'(pq_pkg::CAPACITY)) begin
                            n_status = pq_pkg::ST_FULL;
                        end else begin
                            // write at tail, then walk up
                            n_pos   = r_cnt[AW-1:0];
                            n_cnt   = r_cnt + CW'(1);
                            we      = 1'b1;
                            addr    = r_cnt[AW-1:0];
                            wdata   = i_value[VW-1:0];
                            n_state = (r_cnt == '0) ? pq_pkg::S_TOP_RD : pq_pkg::S_UP_RD;
                        end
                    end else if (i_action == pq_pkg::ACT_POP) begin
                        if (r_cnt == '0) begin
                            n_status = pq_pkg::ST_EMPTY;
                        end else begin
                            n_cnt   = r_cnt - CW'(1);
                            addr    = AW'(r_cnt - CW'(1));
                            n_pos   = '0;
                            n_state = pq_pkg::S_DN_RD0;
                        end
                    end
                end
            end
            pq_pkg::S_UP_RD: begin
                addr    = AW'((r_pos - AW'(1)) >> 1);
                n_best  = addr;
                n_state = pq_pkg::S_UP_CMP;
            end
            pq_pkg::S_UP_CMP: begin
                if (pq_pkg::outranks(r_min, r_cur, rdata)) begin
                    // parent moves down; position written with cur later
                    we    = 1'b1;
                    addr  = r_pos;
                    wdata = rdata;
                    n_pos = r_best;
                    n_state = (r_best == '0) ? pq_pkg::S_TOP_WAIT : pq_pkg::S_UP_RD;
                end else begin
                    we = 1'b1;
                    addr = r_pos;
                    n_state = pq_pkg::S_TOP_RD;
                end
            end
            pq_pkg::S_DN_RD0: begin
                // last entry read data arrives; becomes the sifting value
                n_cur = rdata;
                if (lidx >= (AW+1)'(r_cnt)) begin
                    we = 1'b1; addr = r_pos; wdata = rdata;
                    n_state = pq_pkg::S_TOP_RD;
                end else begin
                    addr = lidx[AW-1:0];
                    n_state = pq_pkg::S_DN_RDL;
                end
            end
            pq_pkg::S_DN_NEXT: begin
                addr = lidx[AW-1:0];
                n_state = pq_pkg::S_DN_RDL;
            end
            pq_pkg::S_DN_RDL: begin
                n_left = rdata;
                n_best = lidx[AW-1:0];
                if (ridx < (AW+1)'(r_cnt)) begin
                    addr = ridx[AW-1:0];
                    n_state = pq_pkg::S_DN_RDR;
                end else begin
                    n_state = pq_pkg::S_DN_CMP;
                end
            end
            pq_pkg::S_DN_RDR: begin
                if (pq_pkg::outranks(r_min, rdata, r_left)) begin
                    n_left = rdata;
                    n_best = ridx[AW-1:0];
                end
                n_state = pq_pkg::S_DN_CMP;
            end
            pq_pkg::S_DN_CMP: begin
                we = 1'b1;
                addr = r_pos;
                if (pq_pkg::outranks(r_min, r_left, r_cur)) begin
                    wdata = r_left;
                    n_pos = r_best;
                    n_state = pq_pkg::S_TOP_WAIT;
                    if ({r_best, 1'b1} < (AW+1)'(r_cnt)) begin
                        // fetch the next left child while holding the hole position
                        n_state = pq_pkg::S_DN_NEXT;
                    end
                end else begin
                    wdata = r_cur;
                    n_state = pq_pkg::S_TOP_RD;
                end
            end
            pq_pkg::S_TOP_WAIT: begin
                // hole at r_pos gets the sifting value
                we = 1'b1;
                addr = r_pos;
                n_state = pq_pkg::S_TOP_RD;
            end
            pq_pkg::S_TOP_RD: begin
                addr = '0;
                n_state = pq_pkg::S_DONE;
            end
            pq_pkg::S_DONE: begin
                n_top = rdata;
                n_state = pq_pkg::S_IDLE;
            end
            default: n_state = pq_pkg::S_IDLE;
        endcase
    end

    // done is registered from the state in which the top read returns
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_done <= 1'b0;
        else          r_done <= (r_state == pq_pkg::S_DONE);
    end

    assign o_busy      = (r_state != pq_pkg::S_IDLE) || r_done;
    assign o_done      = r_done;
    assign o_not_empty = (r_cnt != '0);
    assign o_count     = 7'(r_cnt);
    assign o_top_value = (r_cnt != '0) ? 32'(r_top) : 32'd0;
    assign o_status    = r_status;
endmodule
